@@ rtl/core/sks_pkg.sv @@
// sks_pkg: shared types, constants and helpers for the sorted key set
// depends on nothing; imported by every module of the block

package sks_pkg;

  // number of key slots and the widths that follow from it
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // field widths of the stream payload
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ECOUNT_W = 5;

  // flipping the sign bit makes an unsigned compare follow signed order
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT_UP,
    S_INS_KEY,
    S_SHIFT_DN,
    S_RESP
  } state_e;

  // one result as handed from the controller to the output stage
  typedef struct packed {
    status_e             status;
    logic [POS_W-1:0]    position;
    logic [ECOUNT_W-1:0] entry_count;
  } result_t;

  // mask a slot index or count to the width of the position field
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, v};
    return ext[POS_W-1:0];
  endfunction

  // mask a count to the width of the entry_count field
  function automatic logic [ECOUNT_W-1:0] to_ecount(input logic [CNT_W-1:0] v);
    logic [CNT_W+ECOUNT_W-1:0] ext;
    ext = {{ECOUNT_W{1'b0}}, v};
    return ext[ECOUNT_W-1:0];
  endfunction

endpackage

@@ rtl/core/sks_ram.sv @@
// sks_ram: key storage, one write port and one read port, registered read data
// depends on sks_pkg for DEPTH and the key width

module sks_ram
  import sks_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [KEY_W-1:0] wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [KEY_W-1:0] rdata_o
);

  logic [KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/sks_ctrl.sv @@
// sks_ctrl: request sequencer; linear scan for the sorted position, then
// shifts entries up or down through sks_ram; depends on sks_pkg and sks_ram

module sks_ctrl
  import sks_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request side
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  cmd_e             req_cmd_i,
  input  logic [KEY_W-1:0] req_key_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;
  status_e          status_q, status_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [KEY_W-1:0] wdata;
  logic [IDX_W-1:0] raddr;
  logic [KEY_W-1:0] rdata;

  logic [CNT_W-1:0] ptr_inc, ptr_dec, cnt_dec, idx_inc;

  assign ptr_inc = ptr_q + 1'b1;
  assign ptr_dec = ptr_q - 1'b1;
  assign cnt_dec = count_q - 1'b1;
  assign idx_inc = idx_q + 1'b1;

  // key storage; in the shift states, reads and writes in one cycle hit different slots
  sks_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    status_q <= status_d;
  end

  // next state, memory accesses and result
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    status_d    = status_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = key_q;
    raddr       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d = req_cmd_i;
          key_d = req_key_i ^ SIGN_FLIP;
          idx_d = '0;
          hit_d = 1'b0;
          if (req_cmd_i == CMD_CLEAR || count_q == '0) begin
            state_d = S_EXEC;
          end else begin
            raddr   = '0;
            ptr_d   = CNT_W'(1);
            state_d = S_SCAN;
          end
        end
      end

      // rdata holds slot ptr_q-1; stop at the first key not below the request
      S_SCAN: begin
        if (rdata >= key_q) begin
          idx_d   = ptr_dec;
          hit_d   = (rdata == key_q);
          state_d = S_EXEC;
        end else if (ptr_q == count_q) begin
          idx_d   = count_q;
          hit_d   = 1'b0;
          state_d = S_EXEC;
        end else begin
          raddr = ptr_q[IDX_W-1:0];
          ptr_d = ptr_inc;
        end
      end

      S_EXEC: begin
        status_d = ST_OK;
        state_d  = S_RESP;
        case (cmd_q)
          CMD_INSERT: begin
            if (hit_q) begin
              status_d = ST_MISS;
              idx_d    = '0;
            end else if (count_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
              idx_d    = '0;
            end else if (idx_q == count_q) begin
              // append at the end, nothing to move
              we      = 1'b1;
              waddr   = idx_q[IDX_W-1:0];
              wdata   = key_q;
              count_d = count_q + 1'b1;
            end else begin
              raddr   = cnt_dec[IDX_W-1:0];
              ptr_d   = cnt_dec;
              state_d = S_SHIFT_UP;
            end
          end
          CMD_REMOVE: begin
            if (!hit_q) begin
              status_d = ST_MISS;
              idx_d    = '0;
            end else if (idx_inc == count_q) begin
              count_d = cnt_dec;
            end else begin
              raddr   = idx_inc[IDX_W-1:0];
              ptr_d   = idx_inc;
              state_d = S_SHIFT_DN;
            end
          end
          CMD_FIND: begin
            if (!hit_q) begin
              status_d = ST_MISS;
              idx_d    = '0;
            end
          end
          CMD_CLEAR: begin
            count_d = '0;
            idx_d   = '0;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // move slot ptr_q up by one, walking down toward the insert point
      S_SHIFT_UP: begin
        we    = 1'b1;
        waddr = ptr_inc[IDX_W-1:0];
        wdata = rdata;
        if (ptr_q == idx_q) begin
          state_d = S_INS_KEY;
        end else begin
          raddr = ptr_dec[IDX_W-1:0];
          ptr_d = ptr_dec;
        end
      end

      S_INS_KEY: begin
        we       = 1'b1;
        waddr    = idx_q[IDX_W-1:0];
        wdata    = key_q;
        count_d  = count_q + 1'b1;
        status_d = ST_OK;
        state_d  = S_RESP;
      end

      // move slot ptr_q down by one, walking up toward the last entry
      S_SHIFT_DN: begin
        we    = 1'b1;
        waddr = ptr_dec[IDX_W-1:0];
        wdata = rdata;
        if (ptr_inc == count_q) begin
          count_d  = cnt_dec;
          status_d = ST_OK;
          state_d  = S_RESP;
        end else begin
          raddr = ptr_inc[IDX_W-1:0];
          ptr_d = ptr_inc;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result fields
  assign res_o.status      = status_q;
  assign res_o.position    = to_pos(idx_q);
  assign res_o.entry_count = to_ecount(count_q);

endmodule

@@ rtl/core/sorted_key_set_core.sv @@
// sorted_key_set_core: ordered set of distinct signed keys, DEPTH slots in one RAM
// flow: a request is scanned for its sorted position, slots are moved as needed, and the
//   result passes through an output register to m_axis; clear skips the scan
// throughput: one request at a time; the next is taken once the last result enters the output register
// reset: set empty, no result pending; the key RAM is not cleared

module sorted_key_set_core
  import sks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [1:0] status, [5:2] position, [10:6] entry_count
);

  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_q;
  result_t out_res_q;

  sks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (cmd_e'(s_axis_tuser)),
    .req_key_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees the controller while a result waits
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  // pack result fields, lowest first
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.entry_count, out_res_q.position,
                          out_res_q.status};

endmodule
